/* design/fpba_pkg.sv */
`default_nettype none
package fpba_pkg;

  localparam int unsigned AddrWidth = 20;
  localparam int unsigned DefaultMaxBlocks = 64;
  localparam int unsigned DefaultHeaderBytes = 16;
  localparam logic [AddrWidth-1:0] HeapBytesReset = 20'd65536;

  localparam logic [1:0] PolicyFirst = 2'd0;
  localparam logic [1:0] PolicyWorst = 2'd1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoFit = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;
  localparam logic [1:0] StatusFull = 2'd3;

  localparam logic OpAlloc = 1'b0;

  localparam logic RegFitPolicy = 1'b0;
  localparam logic RegHeapBytes = 1'b1;

  typedef struct packed {
    logic [AddrWidth-1:0] offset;
    logic [AddrWidth-1:0] size;
  } blk_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

endpackage
`default_nettype wire

/* design/fpba_cell.sv */
`default_nettype none
module fpba_cell (
  input  wire                 clk,
  input  wire                 shift,
  input  wire                 write,
  input  fpba_pkg::blk_t      neighbor,
  input  fpba_pkg::blk_t      wr_data,
  output fpba_pkg::blk_t      entry
);

  // A direct write wins over taking the neighbor's entry.
  always_ff @(posedge clk) begin
    if (write) begin
      entry <= wr_data;
    end else if (shift) begin
      entry <= neighbor;
    end
  end

endmodule
`default_nettype wire

/* design/fpba_row.sv */
`default_nettype none
module fpba_row #(
  parameter int unsigned MAX_BLOCKS = fpba_pkg::DefaultMaxBlocks
) (
  input  wire                            clk,
  input  wire                            rotate,
  input  wire                            del_en,
  input  wire [$clog2(MAX_BLOCKS)-1:0]   del_idx,
  input  wire                            wr_en,
  input  wire [$clog2(MAX_BLOCKS)-1:0]   wr_idx,
  input  fpba_pkg::blk_t                 wr_data,
  output fpba_pkg::blk_t                 head
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);

  fpba_pkg::blk_t cells [MAX_BLOCKS];

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    fpba_pkg::blk_t nb;
    logic           sh;
    logic           wr;
    if (k == MAX_BLOCKS - 1) begin : g_last
      assign nb = cells[0];
    end else begin : g_mid
      assign nb = cells[k+1];
    end
    assign sh = rotate || (del_en && (IW'(k) >= del_idx));
    assign wr = wr_en && (IW'(k) == wr_idx);
    fpba_cell u_cell (
      .clk      (clk),
      .shift    (sh),
      .write    (wr),
      .neighbor (nb),
      .wr_data  (wr_data),
      .entry    (cells[k])
    );
  end

  assign head = cells[0];

endmodule
`default_nettype wire

/* design/fit_policy_block_allocator_top.sv */
`default_nettype none
// Fit-policy block allocator. Free and used blocks live in two rows of cells
// that rotate one place per clock while scanning, so each transfer is handled
// by passing the whole list past the head cell. The scan state rotates the
// rows once round and the apply state commits the result to the output
// register; a new transfer is taken only in the idle state, so the block takes
// no item before it is done with the last. Removal from a list and appending
// to it happen in the same cycle at the end. The next item is taken once the
// result has moved to the output register, so a result held by the consumer
// stalls the block. A write of heap_bytes rebuilds the heap as after reset;
// write configuration only while the block is idle.
module fit_policy_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = fpba_pkg::DefaultMaxBlocks,
  parameter int unsigned HEADER_BYTES = fpba_pkg::DefaultHeaderBytes
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         operation,
  input  wire  [19:0] request_size,
  input  wire  [19:0] handle_address,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  status,
  output logic [19:0] payload_address,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [19:0] cfg_data
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [19:0] Hdr = 20'(HEADER_BYTES);
  localparam logic [CW-1:0] Full = CW'(MAX_BLOCKS);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_BLOCKS - 1);

  fpba_pkg::state_t state, state_next;

  logic [1:0]    fit_policy;
  logic [CW-1:0] free_count;
  logic [CW-1:0] used_count;
  logic [IW-1:0] scan_idx;
  logic          op_r;
  logic [19:0]   req_r;
  logic [19:0]   addr_r;
  logic          found;
  logic [IW-1:0] pick_idx;
  fpba_pkg::blk_t pick;

  fpba_pkg::blk_t free_head, used_head;
  logic          rotate;
  logic          f_del, f_wr, u_del, u_wr;
  logic [IW-1:0] f_del_idx, f_wr_idx, u_del_idx, u_wr_idx;
  fpba_pkg::blk_t f_wr_data, u_wr_data;
  logic          commit;
  logic          setup;
  fpba_pkg::blk_t setup_blk;
  fpba_pkg::blk_t rest_blk;
  logic          split;
  logic [1:0]    res_status;
  logic [19:0]   res_addr;
  logic          in_xfer;

  assign in_xfer = in_valid && in_ready;
  assign setup = rst || (cfg_we && cfg_index == fpba_pkg::RegHeapBytes);

  always_comb begin
    setup_blk.offset = '0;
    if (rst) begin
      setup_blk.size = fpba_pkg::HeapBytesReset - Hdr;
    end else begin
      setup_blk.size = (cfg_data > Hdr) ? (cfg_data - Hdr) : '0;
    end
  end

  assign split = {1'b0, pick.size} > ({1'b0, req_r} + {1'b0, Hdr});
  assign rest_blk.offset = pick.offset + req_r + Hdr;
  assign rest_blk.size = pick.size - req_r - Hdr;

  always_comb begin
    if (op_r == fpba_pkg::OpAlloc) begin
      if (!found) begin
        res_status = fpba_pkg::StatusNoFit;
      end else if (used_count == Full) begin
        res_status = fpba_pkg::StatusFull;
      end else begin
        res_status = fpba_pkg::StatusOk;
      end
    end else begin
      if (!found) begin
        res_status = fpba_pkg::StatusNotFound;
      end else if (free_count == Full) begin
        res_status = fpba_pkg::StatusFull;
      end else begin
        res_status = fpba_pkg::StatusOk;
      end
    end
    res_addr = (op_r == fpba_pkg::OpAlloc && res_status == fpba_pkg::StatusOk)
             ? pick.offset + Hdr : '0;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fpba_pkg::ST_IDLE: begin
        if (in_xfer) state_next = fpba_pkg::ST_SCAN;
      end
      fpba_pkg::ST_SCAN: begin
        if (scan_idx == LastIdx) state_next = fpba_pkg::ST_APPLY;
      end
      fpba_pkg::ST_APPLY: begin
        if (!out_valid || out_ready) state_next = fpba_pkg::ST_IDLE;
      end
      default: state_next = fpba_pkg::ST_IDLE;
    endcase
  end

  // Handshake and outputs to the rows.
  always_comb begin
    in_ready = 1'b0;
    rotate = 1'b0;
    commit = 1'b0;
    case (state)
      fpba_pkg::ST_IDLE:  in_ready = 1'b1;
      fpba_pkg::ST_SCAN:  rotate = 1'b1;
      fpba_pkg::ST_APPLY: commit = !out_valid || out_ready;
      default: ;
    endcase
    f_del = 1'b0;
    u_del = 1'b0;
    f_wr = 1'b0;
    u_wr = 1'b0;
    f_del_idx = pick_idx;
    u_del_idx = pick_idx;
    f_wr_idx = free_count[IW-1:0];
    u_wr_idx = used_count[IW-1:0];
    f_wr_data = pick;
    u_wr_data = pick;
    u_wr_data.size = req_r;
    if (setup) begin
      f_wr = 1'b1;
      f_wr_idx = '0;
      f_wr_data = setup_blk;
    end else if (commit && res_status == fpba_pkg::StatusOk) begin
      if (op_r == fpba_pkg::OpAlloc) begin
        f_del = 1'b1;
        u_wr = 1'b1;
        f_wr = split;
        f_wr_idx = IW'(free_count - 1'b1);
        f_wr_data = rest_blk;
      end else begin
        u_del = 1'b1;
        f_wr = 1'b1;
      end
    end
  end

  fpba_row #(.MAX_BLOCKS(MAX_BLOCKS)) u_free_row (
    .clk     (clk),
    .rotate  (rotate),
    .del_en  (f_del),
    .del_idx (f_del_idx),
    .wr_en   (f_wr),
    .wr_idx  (f_wr_idx),
    .wr_data (f_wr_data),
    .head    (free_head)
  );

  fpba_row #(.MAX_BLOCKS(MAX_BLOCKS)) u_used_row (
    .clk     (clk),
    .rotate  (rotate),
    .del_en  (u_del),
    .del_idx (u_del_idx),
    .wr_en   (u_wr),
    .wr_idx  (u_wr_idx),
    .wr_data (u_wr_data),
    .head    (used_head)
  );

  logic in_free, in_used, fits, take;

  always_comb begin
    in_free = CW'(scan_idx) < free_count;
    in_used = CW'(scan_idx) < used_count;
    fits = free_head.size >= req_r;
    take = 1'b0;
    if (op_r == fpba_pkg::OpAlloc) begin
      if (in_free && fits) begin
        if (fit_policy == fpba_pkg::PolicyFirst) begin
          take = !found;
        end else if (fit_policy == fpba_pkg::PolicyWorst) begin
          take = (free_head.size != '0) && (!found || free_head.size > pick.size);
        end else begin
          take = !found || free_head.size < pick.size;
        end
      end
    end else begin
      take = in_used && !found && ((used_head.offset + Hdr) == addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpba_pkg::ST_IDLE;
      fit_policy <= fpba_pkg::PolicyFirst;
      free_count <= CW'(1);
      used_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == fpba_pkg::RegFitPolicy) begin
        fit_policy <= cfg_data[1:0];
      end
      if (setup) begin
        free_count <= CW'(1);
        used_count <= '0;
      end else if (commit && res_status == fpba_pkg::StatusOk) begin
        if (op_r == fpba_pkg::OpAlloc) begin
          used_count <= used_count + 1'b1;
          if (!split) free_count <= free_count - 1'b1;
        end else begin
          used_count <= used_count - 1'b1;
          free_count <= free_count + 1'b1;
        end
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= operation;
      req_r <= request_size;
      addr_r <= handle_address;
      scan_idx <= '0;
      found <= 1'b0;
    end else if (rotate) begin
      scan_idx <= scan_idx + 1'b1;
      if (take) begin
        found <= 1'b1;
        pick_idx <= scan_idx;
        pick <= (op_r == fpba_pkg::OpAlloc) ? free_head : used_head;
      end
    end
    if (commit) begin
      status <= res_status;
      payload_address <= res_addr;
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= Full) else $error("free count above capacity");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= Full) else $error("used count above capacity");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != fpba_pkg::StatusOk) |-> (payload_address == '0))
    else $error("failed transfer carries an address");

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == fpba_pkg::ST_SCAN && scan_idx == LastIdx) |=> (state == fpba_pkg::ST_APPLY))
    else $error("scan did not end after one rotation");

endmodule
`default_nettype wire

/* dv/fit_policy_block_allocator_top_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module fit_policy_block_allocator_top_tb;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned WatchdogLimit = 4000;
  localparam logic [1:0] PolicyBest = 2'd2;
  localparam logic [1:0] PolicyUnused = 2'd3;
  localparam logic OpFree = 1'b1;
  localparam logic OpAlloc = fpba_pkg::OpAlloc;
  localparam logic [19:0] Hdr = 20'(HeaderBytes);

  typedef struct {
    logic        op;
    logic [19:0] req;
    logic [19:0] addr;
    logic        has_expect;
    logic [1:0]  exp_status;
    logic [19:0] exp_address;
  } stim_row_t;

  typedef struct {
    logic [1:0]  status;
    logic [19:0] address;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [19:0] request_size = '0;
  logic [19:0] handle_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [19:0] payload_address;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [19:0] cfg_data = '0;

  fit_policy_block_allocator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .request_size(request_size),
    .handle_address(handle_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .payload_address(payload_address),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  logic [1:0]     policy_q;
  logic [19:0]    heap_q;
  fpba_pkg::blk_t avail_list[$];
  fpba_pkg::blk_t used_list[$];

  alloc_result_t expected_results[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  bit          timed_out = 1'b0;
  int          op_count[2];
  int          status_count[4];

  function automatic void rebuild_heap();
    fpba_pkg::blk_t b;
    avail_list.delete();
    used_list.delete();
    b.offset = '0;
    b.size = (heap_q > Hdr) ? heap_q - Hdr : '0;
    avail_list.push_back(b);
  endfunction

  function automatic int choose_free_block(logic [19:0] req);
    int pick;
    pick = -1;
    for (int i = 0; i < avail_list.size(); i++) begin
      if (avail_list[i].size < req) continue;
      if (policy_q == fpba_pkg::PolicyFirst) return i;
      if (policy_q == fpba_pkg::PolicyWorst) begin
        if (avail_list[i].size != '0 &&
            (pick < 0 || avail_list[i].size > avail_list[pick].size))
          pick = i;
      end else if (pick < 0 || avail_list[i].size < avail_list[pick].size) begin
        pick = i;
      end
    end
    return pick;
  endfunction

  function automatic alloc_result_t predict_heap_op(logic op, logic [19:0] req,
                                                    logic [19:0] addr);
    alloc_result_t r;
    int p;
    fpba_pkg::blk_t b;
    fpba_pkg::blk_t rest;
    r.status = fpba_pkg::StatusOk;
    r.address = '0;
    if (op == OpAlloc) begin
      p = choose_free_block(req);
      if (p < 0) begin
        r.status = fpba_pkg::StatusNoFit;
      end else if (used_list.size() >= MaxBlocks) begin
        r.status = fpba_pkg::StatusFull;
      end else begin
        b = avail_list[p];
        avail_list.delete(p);
        if (33'(b.size) > 33'(req) + 33'(HeaderBytes)) begin
          rest.offset = b.offset + req + Hdr;
          rest.size = b.size - req - Hdr;
          avail_list.push_back(rest);
        end
        b.size = req;
        used_list.push_back(b);
        r.address = b.offset + Hdr;
      end
    end else begin
      r.status = fpba_pkg::StatusNotFound;
      for (int i = 0; i < used_list.size(); i++) begin
        if (used_list[i].offset + Hdr == addr) begin
          if (avail_list.size() >= MaxBlocks) begin
            r.status = fpba_pkg::StatusFull;
          end else begin
            avail_list.push_back(used_list[i]);
            used_list.delete(i);
            r.status = fpba_pkg::StatusOk;
          end
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic write_register(logic index, logic [19:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == fpba_pkg::RegFitPolicy) begin
      policy_q = value[1:0];
    end else begin
      heap_q = value;
      rebuild_heap();
    end
    @(posedge clk);
  endtask

  // Valid is left high after a transfer; the next item or a drain settles it.
  task automatic send_item(stim_row_t row);
    alloc_result_t r;
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= row.op;
    request_size <= row.req;
    handle_address <= row.addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = predict_heap_op(row.op, row.req, row.addr);
    if (row.has_expect && (r.status != row.exp_status || r.address != row.exp_address))
      $display("note: predictor differs from table entry for op %0d", row.op);
    if (row.has_expect) begin
      r.status = row.exp_status;
      r.address = row.exp_address;
    end
    expected_results.push_back(r);
    op_count[row.op]++;
  endtask

  // Wait for every result, then the block latency, before touching registers.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (MaxBlocks + 10) @(posedge clk);
  endtask

  function automatic logic [19:0] pick_live_address();
    if (used_list.size() != 0 && $urandom_range(0, 9) != 0)
      return used_list[$urandom_range(0, used_list.size() - 1)].offset + Hdr;
    return 20'($urandom);
  endfunction

  function automatic logic [19:0] pick_request();
    case ($urandom_range(0, 9))
      0: return 20'($urandom);
      1: return 20'($urandom_range(0, 4));
      default: return 20'($urandom_range(1, 2 * heap_q / 40 + 2));
    endcase
  endfunction

  // Result side: random stall per transfer, compare with oldest expectation.
  initial begin
    alloc_result_t e;
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status %0d", status);
      end else begin
        e = expected_results.pop_front();
        status_count[status]++;
        if (status !== e.status || payload_address !== e.address) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d addr %0h, got status %0d addr %0h",
                     e.status, e.address, status, payload_address);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchdogLimit && !timed_out) begin
      timed_out <= 1'b1;
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    int count;
    policy_q = fpba_pkg::PolicyFirst;
    heap_q = fpba_pkg::HeapBytesReset;
    rebuild_heap();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: {op, req, addr, has_expect, status, address}.
    table_rows.push_back('{OpFree, 20'd0, 20'd16, 1'b1, fpba_pkg::StatusNotFound, 20'd0});
    table_rows.push_back('{OpAlloc, 20'd100, 20'd0, 1'b1, fpba_pkg::StatusOk, 20'd16});
    table_rows.push_back('{OpAlloc, 20'hFFFFF, 20'd0, 1'b1, fpba_pkg::StatusNoFit, 20'd0});
    table_rows.push_back('{OpAlloc, 20'd0, 20'hFFFFF, 1'b0, 2'd0, 20'd0});
    table_rows.push_back('{OpAlloc, 20'd200, 20'd0, 1'b0, 2'd0, 20'd0});
    table_rows.push_back('{OpFree, 20'hFFFFF, 20'd16, 1'b1, fpba_pkg::StatusOk, 20'd0});
    table_rows.push_back('{OpFree, 20'd0, 20'd16, 1'b1, fpba_pkg::StatusNotFound, 20'd0});
    table_rows.push_back('{OpFree, 20'd0, 20'hFFFFF, 1'b1, fpba_pkg::StatusNotFound, 20'd0});
    table_rows.push_back('{OpAlloc, 20'd100, 20'd0, 1'b0, 2'd0, 20'd0});
    table_rows.push_back('{OpAlloc, 20'd90, 20'd0, 1'b0, 2'd0, 20'd0});
    foreach (table_rows[i]) send_item(table_rows[i]);
    drain();

    // Tiny heap smaller than a header: only a zero-size request fits, and under worst fit none does.
    write_register(fpba_pkg::RegHeapBytes, 20'd8);
    row = '{OpAlloc, 20'd1, 20'd0, 1'b1, fpba_pkg::StatusNoFit, 20'd0};
    send_item(row);
    row = '{OpAlloc, 20'd0, 20'd0, 1'b1, fpba_pkg::StatusOk, 20'd16};
    send_item(row);
    drain();
    write_register(fpba_pkg::RegFitPolicy, fpba_pkg::PolicyWorst);
    write_register(fpba_pkg::RegHeapBytes, 20'd8);
    row = '{OpAlloc, 20'd0, 20'd0, 1'b1, fpba_pkg::StatusNoFit, 20'd0};
    send_item(row);
    drain();
    // Exact fit on the largest heap, and a table-full run on a small one.
    write_register(fpba_pkg::RegHeapBytes, 20'hFFFFF);
    row = '{OpAlloc, 20'hFFFEF, 20'd0, 1'b1, fpba_pkg::StatusOk, 20'd16};
    send_item(row);
    drain();
    write_register(fpba_pkg::RegFitPolicy, fpba_pkg::PolicyFirst);
    write_register(fpba_pkg::RegHeapBytes, 20'd4096);
    for (int i = 0; i < 66; i++) begin
      row = '{OpAlloc, 20'd0, 20'd0, 1'b0, 2'd0, 20'd0};
      send_item(row);
    end
    drain();

    // Random phases over every policy, with heap sizes from small to largest.
    count = 0;
    for (int phase = 0; count < RandomItems; phase++) begin
      write_register(fpba_pkg::RegFitPolicy, 2'(phase % 4));
      case (phase % 5)
        0: write_register(fpba_pkg::RegHeapBytes, 20'd32);
        1: write_register(fpba_pkg::RegHeapBytes, 20'hFFFFF);
        default: write_register(fpba_pkg::RegHeapBytes,
                                20'($urandom_range(32, 20'hFFFFF)));
      endcase
      for (int i = 0; i < 110 && count < RandomItems; i++) begin
        row.op = ($urandom_range(0, 99) < 55) ? OpAlloc : OpFree;
        row.req = pick_request();
        row.addr = pick_live_address();
        row.has_expect = 1'b0;
        row.exp_status = '0;
        row.exp_address = '0;
        send_item(row);
        count++;
      end
      drain();
    end
    write_register(fpba_pkg::RegFitPolicy, PolicyUnused);

    drain();
    $display("Ran %0d allocates and %0d frees; %0d results checked.",
             op_count[0], op_count[1], results_seen);
    $display("Statuses seen: ok %0d, no fit %0d, not found %0d, full %0d.",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
